@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the field line parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/lfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lfp_pkg
// Types and constants of the literal field line parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_FIRST     = 3'd0,
      PH_NAME_INT  = 3'd1,
      PH_NAME_STR  = 3'd2,
      PH_VALUE_HDR = 3'd3,
      PH_VALUE_INT = 3'd4,
      PH_VALUE_STR = 3'd5,
      PH_ERROR     = 3'd6
   } phase_type;

   // Byte kind codes
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_VALUE  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INT     = 2'd1;
   localparam logic [1:0] STATUS_BUFFER  = 2'd2;
   localparam logic [1:0] STATUS_PATTERN = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_CAP  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_CAP = 4'd1;
   localparam logic [15:0] CAP_RESET = 16'd4096;

   // Prefix integer limits
   localparam logic [2:0] FIRST_PATTERN    = 3'b001;
   localparam logic [2:0] NAME_PREFIX_MAX  = 3'h7;
   localparam logic [6:0] VALUE_PREFIX_MAX = 7'h7F;
   localparam logic [3:0] CONT_LIMIT       = 4'd10;
   localparam logic [5:0] SHIFT_GUARD      = 6'd56;
   localparam logic [5:0] SHIFT_STEP       = 6'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] byte_kind;
      logic       huffman_coded;
      logic       no_index;
      logic       line_done;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] acc;
      logic [5:0]  shift;
      logic [3:0]  count;
      logic [61:0] left;
      logic        ni;
      logic        huff;
      logic [1:0]  err;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_FIRST, acc: 64'd0, shift: 6'd0, count: 4'd0,
      left: 62'd0, ni: 1'b0, huff: 1'b0, err: STATUS_OK
   };

   typedef struct packed {
      logic [15:0] name_cap;
      logic [15:0] value_cap;
   } cfg_type;

endpackage

@@ design/lfp_step.sv @@
// ----------------------------------------------------------------------------
// lfp_step
// One parse step: next parser state and the result word for one input byte.
// ----------------------------------------------------------------------------
module lfp_step (
   input  lfp_pkg::state_type    state,
   input  lfp_pkg::req_word_type req_word,
   input  lfp_pkg::cfg_type      cfg,
   output lfp_pkg::state_type    state_next,
   output lfp_pkg::rsp_word_type rsp_word
);
   import lfp_pkg::*;

   // Raw strings longer than the capacity are rejected
   function automatic logic len_over(input logic huff, input logic [63:0] len,
                                     input logic [15:0] cap);
      len_over = !huff && (len > {48'd0, cap});
   endfunction

   state_type   cur;
   state_type   nxt;
   logic [7:0]  b;
   logic [1:0]  kind;
   logic        done;
   logic        hf;
   logic [3:0]  cnt_inc;
   logic [63:0] add_val;
   logic [64:0] acc_sum;
   logic        int_err;
   logic [63:0] len;

   always_comb begin
      b = req_word.data_byte;

      // Drop any line in progress and any error on line start
      cur = state;
      if (req_word.line_start) begin
         cur.phase = PH_FIRST;
         cur.err   = STATUS_OK;
      end

      // Prefix integer continuation: count, shift guard, carry, final limit
      cnt_inc = cur.count + 4'd1;
      add_val = {57'd0, b[6:0]} << cur.shift;
      acc_sum = {1'b0, cur.acc} + {1'b0, add_val};
      int_err = (cnt_inc > CONT_LIMIT) || (cur.shift > SHIFT_GUARD) || acc_sum[64]
                || (!b[7] && (acc_sum[63:62] != 2'b00));

      nxt  = cur;
      kind = KIND_HEADER;
      done = 1'b0;
      hf   = 1'b0;
      len  = 64'd0;

      case (cur.phase)
         PH_FIRST: begin
            if (b[7:5] != FIRST_PATTERN) begin
               nxt.ni    = 1'b0;
               nxt.phase = PH_ERROR;
               nxt.err   = STATUS_PATTERN;
            end else begin
               nxt.ni   = b[4];
               nxt.huff = b[3];
               len      = {61'd0, b[2:0]};
               if (b[2:0] != NAME_PREFIX_MAX) begin
                  if (len_over(b[3], len, cfg.name_cap)) begin
                     nxt.phase = PH_ERROR;
                     nxt.err   = STATUS_BUFFER;
                  end else if (b[2:0] == 3'd0) begin
                     nxt.phase = PH_VALUE_HDR;
                  end else begin
                     nxt.left  = len[61:0];
                     nxt.phase = PH_NAME_STR;
                  end
               end else begin
                  nxt.acc   = {61'd0, NAME_PREFIX_MAX};
                  nxt.shift = 6'd0;
                  nxt.count = 4'd0;
                  nxt.phase = PH_NAME_INT;
               end
            end
         end
         PH_NAME_INT: begin
            nxt.count = cnt_inc;
            if (int_err) begin
               nxt.phase = PH_ERROR;
               nxt.err   = STATUS_INT;
            end else begin
               nxt.acc   = acc_sum[63:0];
               nxt.shift = cur.shift + SHIFT_STEP;
               len       = acc_sum[63:0];
               // bit 7 clear ends the integer
               if (!b[7]) begin
                  if (len_over(cur.huff, len, cfg.name_cap)) begin
                     nxt.phase = PH_ERROR;
                     nxt.err   = STATUS_BUFFER;
                  end else if (len == 64'd0) begin
                     nxt.phase = PH_VALUE_HDR;
                  end else begin
                     nxt.left  = len[61:0];
                     nxt.phase = PH_NAME_STR;
                  end
               end
            end
         end
         PH_NAME_STR: begin
            kind     = KIND_NAME;
            hf       = cur.huff;
            nxt.left = cur.left - 62'd1;
            if (nxt.left == 62'd0) begin
               nxt.phase = PH_VALUE_HDR;
            end
         end
         PH_VALUE_HDR: begin
            nxt.huff = b[7];
            len      = {57'd0, b[6:0]};
            if (b[6:0] != VALUE_PREFIX_MAX) begin
               if (len_over(b[7], len, cfg.value_cap)) begin
                  nxt.phase = PH_ERROR;
                  nxt.err   = STATUS_BUFFER;
               end else if (b[6:0] == 7'd0) begin
                  nxt.phase = PH_FIRST;
                  done      = 1'b1;
               end else begin
                  nxt.left  = len[61:0];
                  nxt.phase = PH_VALUE_STR;
               end
            end else begin
               nxt.acc   = {57'd0, VALUE_PREFIX_MAX};
               nxt.shift = 6'd0;
               nxt.count = 4'd0;
               nxt.phase = PH_VALUE_INT;
            end
         end
         PH_VALUE_INT: begin
            nxt.count = cnt_inc;
            if (int_err) begin
               nxt.phase = PH_ERROR;
               nxt.err   = STATUS_INT;
            end else begin
               nxt.acc   = acc_sum[63:0];
               nxt.shift = cur.shift + SHIFT_STEP;
               len       = acc_sum[63:0];
               if (!b[7]) begin
                  if (len_over(cur.huff, len, cfg.value_cap)) begin
                     nxt.phase = PH_ERROR;
                     nxt.err   = STATUS_BUFFER;
                  end else if (len == 64'd0) begin
                     nxt.phase = PH_FIRST;
                     done      = 1'b1;
                  end else begin
                     nxt.left  = len[61:0];
                     nxt.phase = PH_VALUE_STR;
                  end
               end
            end
         end
         PH_VALUE_STR: begin
            kind     = KIND_VALUE;
            hf       = cur.huff;
            nxt.left = cur.left - 62'd1;
            if (nxt.left == 62'd0) begin
               nxt.phase = PH_FIRST;
               done      = 1'b1;
            end
         end
         default: begin
            // error phase: ignore the byte
         end
      endcase

      state_next = nxt;

      // Build the result word
      rsp_word.out_byte      = (kind != KIND_HEADER) ? b : 8'd0;
      rsp_word.byte_kind     = kind;
      rsp_word.huffman_coded = hf;
      rsp_word.no_index      = nxt.ni;
      rsp_word.line_done     = done;
      rsp_word.status        = (nxt.phase == PH_ERROR) ? nxt.err : STATUS_OK;
   end

endmodule

@@ design/lfp_rsp_skid.sv @@
// ----------------------------------------------------------------------------
// lfp_rsp_skid
// Result register with a skid stage so the input side keeps flowing.
// ----------------------------------------------------------------------------
module lfp_rsp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lfp_pkg::rsp_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lfp_pkg::rsp_word_type out_word
);
   import lfp_pkg::*;

   logic         main_valid_ff;
   logic         main_valid_in;
   rsp_word_type main_ff;
   rsp_word_type main_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_word_type skid_ff;
   rsp_word_type skid_in;
   logic         push;
   logic         take;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;
   assign push      = in_valid && in_ready;
   assign take      = main_valid_ff && out_ready;

   // Advance skid into main on take, otherwise park the new word
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_word;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = in_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ design/literal_field_line_parser.sv @@
// ----------------------------------------------------------------------------
// literal_field_line_parser
// Byte-wide parser for literal-name field lines; tags name and value bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one encoded byte per word, with line_start marking the first
//   byte of a field line. rsp_* returns exactly one result word per request
//   word, in order, tagging string bytes as name or value with their flags.
//   csr_* writes the name and value capacities (index 0 and 1); other
//   indexes are accepted and ignored. csr_ready is always high.
// Timing:
//   A request word's result word is registered on accept, into the result
//   register or, while that holds an untaken word, into the skid word. One
//   word per cycle is sustained while the receiver takes words: the parser
//   state, the 64-bit prefix integer add and capacity compare update on accept.
// Stall:
//   A result register plus one skid word part the channels; req_ready drops
//   only while both hold words the receiver has not taken.
// Reset:
//   Synchronous. The parser waits for a first byte, capacities return to
//   4096, and both result words are emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module literal_field_line_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lfp_pkg::req_word_type                 req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lfp_pkg::rsp_word_type                 rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lfp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [15:0]                           csr_data
);
   import lfp_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   rsp_word_type step_word;
   logic         req_accept;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;

   // Write capacity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_cap  <= CAP_RESET;
         cfg_ff.value_cap <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NAME_CAP:  cfg_ff.name_cap  <= csr_data;
            CSR_VALUE_CAP: cfg_ff.value_cap <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lfp_step u_step (
      .state      (state_ff),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .rsp_word   (step_word)
   );

   // Advance parser state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   lfp_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (step_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

   // Checks
   `ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid)
   `ASSERT_IMPLIES(a_err_matches_phase, clock, reset, 1'b1,
      (state_ff.phase == PH_ERROR) == (state_ff.err != STATUS_OK))
   `ASSERT_IMPLIES(a_string_ok, clock, reset,
      rsp_valid && (rsp_word.byte_kind != KIND_HEADER), rsp_word.status == STATUS_OK)
   `ASSERT_IMPLIES(a_done_not_name, clock, reset,
      rsp_valid && rsp_word.line_done, rsp_word.byte_kind != KIND_NAME)

endmodule
